### src/rph_pkg.sv
// shared types and constants of the rolling polynomial hash unit
package rph_pkg;

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_ROLL    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_PREPARE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_BASE    = 2'd0,
        CFG_MODULUS = 2'd1,
        CFG_WINDOW  = 2'd2,
        CFG_NONE    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MM_MUL = 2'd0,
        MM_ADD = 2'd1,
        MM_SUB = 2'd2
    } mm_mode_t;

    typedef struct packed {
        logic     start;
        mm_mode_t mode;
    } mm_ctl_t;

    typedef struct packed {
        logic base_wr;
        logic mod_wr;
    } cfg_evt_t;

    localparam logic [31:0] BASE_RST    = 32'd31;
    localparam logic [31:0] MODULUS_RST = 32'd1000000007;
    localparam logic [15:0] WINDOW_RST  = 16'd48;
    localparam int          BYTE_BITS   = 8;

endpackage

### src/rph_mulmod.sv
// shared bit-serial modular multiply, add and subtract unit
module rph_mulmod #(
    parameter int HASH_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rph_pkg::mm_ctl_t                  ctl,
    input  logic [HASH_WIDTH-1:0]             acc_init,
    input  logic [HASH_WIDTH-1:0]             scan_init,
    input  logic [$clog2(HASH_WIDTH+1)-1:0]   nbits,
    input  logic [HASH_WIDTH-1:0]             addend,
    input  logic [HASH_WIDTH-1:0]             modulus,
    output logic                              done,
    output logic [HASH_WIDTH-1:0]             result
);

    localparam int CW = $clog2(HASH_WIDTH+1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    rph_pkg::mm_mode_t     mode_reg, mode_next;
    logic [HASH_WIDTH-1:0] acc_reg, acc_next;
    logic [HASH_WIDTH-1:0] scan_reg, scan_next;
    logic [HASH_WIDTH-1:0] addend_reg, addend_next;
    logic [CW-1:0]         cnt_reg, cnt_next;

    logic [HASH_WIDTH:0]   mod_w, dbl_w, dred_w, base_w, add_w, sum_w, red_w, diff_w, sub_w;
    logic [HASH_WIDTH-1:0] step;

    always_comb begin
        mod_w  = {1'b0, modulus};
        dbl_w  = {acc_reg, 1'b0};
        dred_w = (dbl_w >= mod_w) ? dbl_w - mod_w : dbl_w;
        base_w = (mode_reg == rph_pkg::MM_MUL) ? dred_w : {1'b0, acc_reg};
        add_w  = (mode_reg == rph_pkg::MM_ADD || scan_reg[HASH_WIDTH-1]) ?
                 {1'b0, addend_reg} : '0;
        sum_w  = base_w + add_w;
        red_w  = (sum_w >= mod_w) ? sum_w - mod_w : sum_w;
        diff_w = {1'b0, acc_reg} - {1'b0, addend_reg};
        sub_w  = diff_w[HASH_WIDTH] ? diff_w + mod_w : diff_w;
        case (mode_reg)
            rph_pkg::MM_MUL: step = red_w[HASH_WIDTH-1:0];
            rph_pkg::MM_ADD: step = red_w[HASH_WIDTH-1:0];
            rph_pkg::MM_SUB: step = sub_w[HASH_WIDTH-1:0];
            default:         step = acc_reg;
        endcase
    end

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        scan_next   = scan_reg;
        addend_next = addend_reg;
        cnt_next    = cnt_reg;
        if (ctl.start) begin
            busy_next   = 1'b1;
            mode_next   = ctl.mode;
            acc_next    = acc_init;
            scan_next   = scan_init;
            addend_next = addend;
            cnt_next    = nbits;
        end else if (busy_reg) begin
            acc_next  = step;
            scan_next = {scan_reg[HASH_WIDTH-2:0], 1'b0};
            cnt_next  = cnt_reg - CW'(1);
            if (mode_reg != rph_pkg::MM_MUL || cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        mode_reg   <= mode_next;
        acc_reg    <= acc_next;
        scan_reg   <= scan_next;
        addend_reg <= addend_next;
        cnt_reg    <= cnt_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### src/rph_seq.sv
// request sequencer and hash state of the rolling polynomial hash unit
module rph_seq #(
    parameter int HASH_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    output logic                              in_ready,
    input  logic                              in_accept,
    input  rph_pkg::req_t                     in_req,
    input  logic [7:0]                        in_new_byte,
    input  logic [7:0]                        in_old_byte,
    input  logic [HASH_WIDTH-1:0]             base,
    input  logic [HASH_WIDTH-1:0]             modulus,
    input  logic [15:0]                       window_len,
    input  rph_pkg::cfg_evt_t                 cfg_evt,
    input  logic                              out_free,
    output logic                              res_load,
    output logic [HASH_WIDTH-1:0]             res_hash,
    output rph_pkg::mm_ctl_t                  mm_ctl,
    output logic [HASH_WIDTH-1:0]             mm_acc_init,
    output logic [HASH_WIDTH-1:0]             mm_scan_init,
    output logic [$clog2(HASH_WIDTH+1)-1:0]   mm_nbits,
    output logic [HASH_WIDTH-1:0]             mm_addend,
    input  logic                              mm_done,
    input  logic [HASH_WIDTH-1:0]             mm_result
);

    localparam int CW         = $clog2(HASH_WIDTH+1);
    localparam int BYTE_SHIFT = HASH_WIDTH - rph_pkg::BYTE_BITS;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_BRED  = 12'b0000_0000_0010,
        ST_PRED  = 12'b0000_0000_0100,
        ST_HRED  = 12'b0000_0000_1000,
        ST_RSUBW = 12'b0000_0001_0000,
        ST_RSUB  = 12'b0000_0010_0000,
        ST_MULB  = 12'b0000_0100_0000,
        ST_NRED  = 12'b0000_1000_0000,
        ST_NADD  = 12'b0001_0000_0000,
        ST_PLOOP = 12'b0010_0000_0000,
        ST_PSET  = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic                  go_reg, go_next;
    rph_pkg::req_t         req_reg, req_next;
    logic [7:0]            nb_reg, nb_next;
    logic [7:0]            ob_reg, ob_next;
    logic [HASH_WIDTH-1:0] hash_reg, hash_next;
    logic                  hash_ok_reg, hash_ok_next;
    logic [HASH_WIDTH-1:0] power_reg, power_next;
    logic [HASH_WIDTH-1:0] power_red_reg, power_red_next;
    logic                  power_ok_reg, power_ok_next;
    logic [HASH_WIDTH-1:0] base_red_reg, base_red_next;
    logic                  base_ok_reg, base_ok_next;
    logic [HASH_WIDTH-1:0] tmp_reg, tmp_next;
    logic [HASH_WIDTH-1:0] nbr_reg, nbr_next;
    logic [15:0]           loop_reg, loop_next;

    logic                  m_small, m_big;
    logic [15:0]           prep_n;

    function automatic state_t route(input rph_pkg::req_t r, input logic pok,
                                     input logic hok, input logic lz);
        state_t s;
        case (r)
            rph_pkg::REQ_APPEND:  s = ST_MULB;
            rph_pkg::REQ_ROLL:    s = !pok ? ST_PRED : (!hok ? ST_HRED : ST_RSUBW);
            rph_pkg::REQ_PREPARE: s = lz ? ST_PSET : ST_PLOOP;
            default:              s = ST_FIN;
        endcase
        return s;
    endfunction

    assign m_small = modulus < HASH_WIDTH'(2);
    assign m_big   = modulus > HASH_WIDTH'(255);
    assign prep_n  = (window_len == 16'd0) ? 16'd0 : window_len - 16'd1;

    always_comb begin
        state_next     = state_reg;
        go_next        = go_reg;
        req_next       = req_reg;
        nb_next        = nb_reg;
        ob_next        = ob_reg;
        hash_next      = hash_reg;
        hash_ok_next   = hash_ok_reg;
        power_next     = power_reg;
        power_red_next = power_red_reg;
        power_ok_next  = power_ok_reg;
        base_red_next  = base_red_reg;
        base_ok_next   = base_ok_reg;
        tmp_next       = tmp_reg;
        nbr_next       = nbr_reg;
        loop_next      = loop_reg;
        in_ready       = 1'b0;
        res_load       = 1'b0;
        mm_ctl.start   = 1'b0;
        mm_ctl.mode    = rph_pkg::MM_MUL;
        mm_acc_init    = '0;
        mm_scan_init   = '0;
        mm_nbits       = CW'(HASH_WIDTH);
        mm_addend      = HASH_WIDTH'(1);

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    req_next = in_req;
                    nb_next  = in_new_byte;
                    ob_next  = in_old_byte;
                    if (m_small) begin
                        hash_next = '0;
                        if (in_req == rph_pkg::REQ_PREPARE) begin
                            power_next     = '0;
                            power_red_next = '0;
                        end
                        state_next = ST_FIN;
                    end else if (in_req == rph_pkg::REQ_CLEAR) begin
                        hash_next    = '0;
                        hash_ok_next = 1'b1;
                        state_next   = ST_FIN;
                    end else begin
                        tmp_next   = HASH_WIDTH'(1);
                        loop_next  = prep_n;
                        go_next    = 1'b1;
                        state_next = base_ok_reg ?
                                     route(in_req, power_ok_reg, hash_ok_reg,
                                           prep_n == 16'd0) : ST_BRED;
                    end
                end
            end
            ST_BRED: begin
                mm_scan_init = base;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    base_red_next = mm_result;
                    base_ok_next  = 1'b1;
                    go_next       = 1'b1;
                    state_next    = route(req_reg, power_ok_reg, hash_ok_reg,
                                          loop_reg == 16'd0);
                end
            end
            ST_PRED: begin
                mm_scan_init = power_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    power_red_next = mm_result;
                    power_ok_next  = 1'b1;
                    go_next        = 1'b1;
                    state_next     = hash_ok_reg ? ST_RSUBW : ST_HRED;
                end
            end
            ST_HRED: begin
                mm_scan_init = hash_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    hash_next    = mm_result;
                    hash_ok_next = 1'b1;
                    go_next      = 1'b1;
                    state_next   = ST_RSUBW;
                end
            end
            ST_RSUBW: begin
                mm_scan_init = HASH_WIDTH'(ob_reg) << BYTE_SHIFT;
                mm_nbits     = CW'(rph_pkg::BYTE_BITS);
                mm_addend    = power_red_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    tmp_next   = mm_result;
                    go_next    = 1'b1;
                    state_next = ST_RSUB;
                end
            end
            ST_RSUB: begin
                mm_ctl.mode = rph_pkg::MM_SUB;
                mm_acc_init = hash_reg;
                mm_addend   = tmp_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    tmp_next   = mm_result;
                    go_next    = 1'b1;
                    state_next = ST_MULB;
                end
            end
            ST_MULB: begin
                mm_scan_init = (req_reg == rph_pkg::REQ_ROLL) ? tmp_reg : hash_reg;
                mm_addend    = base_red_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    tmp_next = mm_result;
                    go_next  = 1'b1;
                    if (m_big) begin
                        nbr_next   = HASH_WIDTH'(nb_reg);
                        state_next = ST_NADD;
                    end else begin
                        state_next = ST_NRED;
                    end
                end
            end
            ST_NRED: begin
                mm_scan_init = HASH_WIDTH'(nb_reg) << BYTE_SHIFT;
                mm_nbits     = CW'(rph_pkg::BYTE_BITS);
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    nbr_next   = mm_result;
                    go_next    = 1'b1;
                    state_next = ST_NADD;
                end
            end
            ST_NADD: begin
                mm_ctl.mode = rph_pkg::MM_ADD;
                mm_acc_init = tmp_reg;
                mm_addend   = nbr_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    hash_next    = mm_result;
                    hash_ok_next = 1'b1;
                    state_next   = ST_FIN;
                end
            end
            ST_PLOOP: begin
                mm_scan_init = tmp_reg;
                mm_addend    = base_red_reg;
                if (go_reg) begin
                    mm_ctl.start = 1'b1;
                    go_next      = 1'b0;
                end else if (mm_done) begin
                    tmp_next  = mm_result;
                    loop_next = loop_reg - 16'd1;
                    if (loop_reg == 16'd1) begin
                        state_next = ST_PSET;
                    end else begin
                        go_next = 1'b1;
                    end
                end
            end
            ST_PSET: begin
                go_next        = 1'b0;
                power_next     = tmp_reg;
                power_red_next = tmp_reg;
                power_ok_next  = 1'b1;
                hash_next      = '0;
                hash_ok_next   = 1'b1;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                go_next = 1'b0;
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
                go_next    = 1'b0;
            end
        endcase

        // cached reductions go stale when base or modulus change
        if (cfg_evt.base_wr) begin
            base_ok_next = 1'b0;
        end
        if (cfg_evt.mod_wr) begin
            base_ok_next  = 1'b0;
            power_ok_next = 1'b0;
            hash_ok_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            hash_reg      <= '0;
            hash_ok_reg   <= 1'b1;
            power_reg     <= HASH_WIDTH'(1);
            power_red_reg <= HASH_WIDTH'(1);
            power_ok_reg  <= 1'b1;
            base_ok_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            hash_reg      <= hash_next;
            hash_ok_reg   <= hash_ok_next;
            power_reg     <= power_next;
            power_red_reg <= power_red_next;
            power_ok_reg  <= power_ok_next;
            base_ok_reg   <= base_ok_next;
        end
        req_reg      <= req_next;
        nb_reg       <= nb_next;
        ob_reg       <= ob_next;
        base_red_reg <= base_red_next;
        tmp_reg      <= tmp_next;
        nbr_reg      <= nbr_next;
        loop_reg     <= loop_next;
    end

    assign res_hash = hash_reg;

endmodule

### src/rolling_polynomial_hash_unit.sv
// top level of the rolling polynomial hash unit
//
// Keeps a running hash (hash * base + byte) mod modulus. Each item on the
// s_ channel is a request in s_tuser: append, roll, clear or prepare.
// Every item gives exactly one item on the m_ channel, the hash after it.
// Base, modulus and window length are written through cfg_wr_en, cfg_addr
// and cfg_wr_data; the user must write them only while no item is in flight,
// which the block itself does not enforce.
// One bit-serial modular multiply unit does all arithmetic, one multiplier
// bit per cycle. A clear, or any request with modulus below two, gives a
// hash of zero without it; append and roll first reduce the new byte when
// modulus is below 256, and prepare multiplies by base once per window byte
// after the first. The first request after a base or modulus write first
// reduces each cached operand it needs.
// s_tready is high only while the unit is idle, from the cycle after the
// result is loaded, so a new item is not taken before the last result is loaded.
// The result sits in an output register; the next item is taken while it
// waits, and a finished result is held until the receiver takes the previous one.
// Synchronous reset restores the reset registers, clears the hash and sets
// the window power to one.
module rolling_polynomial_hash_unit #(
    parameter int HASH_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // new_byte[7:0], old_byte[15:8]
    input  logic [1:0]  s_tuser,     // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // hash_value[31:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data
);

    localparam int CW = $clog2(HASH_WIDTH+1);

    logic [HASH_WIDTH-1:0] base_reg, base_next;
    logic [HASH_WIDTH-1:0] modulus_reg, modulus_next;
    logic [15:0]           wlen_reg, wlen_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [HASH_WIDTH-1:0] m_tdata_reg, m_tdata_next;

    rph_pkg::cfg_evt_t     cfg_evt;
    rph_pkg::cfg_idx_t     cfg_idx;
    rph_pkg::mm_ctl_t      mm_ctl;
    logic                  in_ready, in_accept, out_free, res_load, mm_done;
    logic [HASH_WIDTH-1:0] res_hash, mm_acc_init, mm_scan_init, mm_addend, mm_result;
    logic [CW-1:0]         mm_nbits;

    assign cfg_idx         = rph_pkg::cfg_idx_t'(cfg_addr);
    assign cfg_evt.base_wr = cfg_wr_en && (cfg_idx == rph_pkg::CFG_BASE);
    assign cfg_evt.mod_wr  = cfg_wr_en && (cfg_idx == rph_pkg::CFG_MODULUS);

    assign s_tready  = in_ready;
    assign in_accept = s_tvalid && in_ready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        base_next     = base_reg;
        modulus_next  = modulus_reg;
        wlen_next     = wlen_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (cfg_wr_en) begin
            case (cfg_idx)
                rph_pkg::CFG_BASE:    base_next    = cfg_wr_data[HASH_WIDTH-1:0];
                rph_pkg::CFG_MODULUS: modulus_next = cfg_wr_data[HASH_WIDTH-1:0];
                rph_pkg::CFG_WINDOW:  wlen_next    = cfg_wr_data[15:0];
                default: ;
            endcase
        end
        if (res_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res_hash;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= rph_pkg::BASE_RST[HASH_WIDTH-1:0];
            modulus_reg  <= rph_pkg::MODULUS_RST[HASH_WIDTH-1:0];
            wlen_reg     <= rph_pkg::WINDOW_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            base_reg     <= base_next;
            modulus_reg  <= modulus_next;
            wlen_reg     <= wlen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = 32'(m_tdata_reg);

    rph_seq #(
        .HASH_WIDTH(HASH_WIDTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ready     (in_ready),
        .in_accept    (in_accept),
        .in_req       (rph_pkg::req_t'(s_tuser)),
        .in_new_byte  (s_tdata[7:0]),
        .in_old_byte  (s_tdata[15:8]),
        .base         (base_reg),
        .modulus      (modulus_reg),
        .window_len   (wlen_reg),
        .cfg_evt      (cfg_evt),
        .out_free     (out_free),
        .res_load     (res_load),
        .res_hash     (res_hash),
        .mm_ctl       (mm_ctl),
        .mm_acc_init  (mm_acc_init),
        .mm_scan_init (mm_scan_init),
        .mm_nbits     (mm_nbits),
        .mm_addend    (mm_addend),
        .mm_done      (mm_done),
        .mm_result    (mm_result)
    );

    rph_mulmod #(
        .HASH_WIDTH(HASH_WIDTH)
    ) u_mulmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mm_ctl),
        .acc_init  (mm_acc_init),
        .scan_init (mm_scan_init),
        .nbits     (mm_nbits),
        .addend    (mm_addend),
        .modulus   (modulus_reg),
        .done      (mm_done),
        .result    (mm_result)
    );

endmodule

### verif/rolling_hash_checker.sv
// checker: predicts the hash after each accepted request and compares it with the results
`timescale 1ns / 100ps
module rolling_hash_checker #(
    parameter int HASH_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,     // new_byte[7:0], old_byte[15:8]
    input  logic [1:0]  s_tuser,     // req_type[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,     // hash_value[31:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wr_data,
    output int          hash_errors,
    output int          hashes_compared,
    output int          hashes_pending
);

    localparam logic [63:0] WIDTH_MASK = (64'd1 << HASH_WIDTH) - 64'd1;

    logic [31:0] base_reg;
    logic [31:0] modulus_reg;
    logic [15:0] window_reg;
    logic [31:0] hash_acc;
    logic [31:0] window_power;
    logic [31:0] expected_hash[$];

    function automatic logic [31:0] mod_reduce(input logic [63:0] v, input logic [63:0] m);
        if (m < 64'd2) return '0;
        return 32'(v % m);
    endfunction

    task automatic apply_request(input rph_pkg::req_t req, input logic [7:0] nb,
                                 input logic [7:0] ob);
        logic [63:0] base;
        logic [63:0] m;
        logic [63:0] sub;
        logic [63:0] h;
        logic [63:0] p;
        int unsigned steps;
        base = 64'(base_reg) & WIDTH_MASK;
        m    = 64'(modulus_reg) & WIDTH_MASK;
        case (req)
            rph_pkg::REQ_APPEND: begin
                hash_acc = mod_reduce(64'(hash_acc) * base + 64'(nb), m);
            end
            rph_pkg::REQ_ROLL: begin
                sub = 64'(mod_reduce(64'(ob) * 64'(window_power), m));
                h = 64'(hash_acc) + m - sub;
                h = 64'(mod_reduce(h, m));
                hash_acc = mod_reduce(h * base + 64'(nb), m);
            end
            rph_pkg::REQ_CLEAR: begin
                hash_acc = '0;
            end
            default: begin
                // window length zero behaves like one
                steps = (window_reg == 16'd0) ? 0 : int'(window_reg) - 1;
                p = 64'(mod_reduce(64'd1, m));
                for (int unsigned i = 0; i < steps; i++) p = 64'(mod_reduce(p * base, m));
                window_power = 32'(p);
                hash_acc = '0;
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        logic [31:0] want;
        if (!aresetn) begin
            base_reg     = rph_pkg::BASE_RST;
            modulus_reg  = rph_pkg::MODULUS_RST;
            window_reg   = rph_pkg::WINDOW_RST;
            hash_acc     = '0;
            window_power = 32'd1;
            expected_hash.delete();
            hash_errors     <= 0;
            hashes_compared <= 0;
            hashes_pending  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_hash.size() == 0) begin
                    $error("unexpected hash_value %h with no request outstanding", m_tdata);
                    hash_errors <= hash_errors + 1;
                end else begin
                    want = expected_hash.pop_front();
                    hashes_compared <= hashes_compared + 1;
                    if (m_tdata !== want) begin
                        $error("hash_value mismatch: expected %h, actual %h", want, m_tdata);
                        hash_errors <= hash_errors + 1;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    rph_pkg::CFG_BASE:    base_reg    = cfg_wr_data;
                    rph_pkg::CFG_MODULUS: modulus_reg = cfg_wr_data;
                    rph_pkg::CFG_WINDOW:  window_reg  = cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                apply_request(rph_pkg::req_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]);
                expected_hash.push_back(hash_acc & WIDTH_MASK[31:0]);
            end
            hashes_pending <= expected_hash.size();
        end
    end

endmodule

### verif/rolling_polynomial_hash_unit_test.sv
// testbench top: drives requests and register writes into the hash unit and reports the verdict
`timescale 1ns / 100ps
module rolling_polynomial_hash_unit_test;

    localparam int ITEMS_PER_PHASE = 240;
    localparam int RANDOM_PHASES   = 8;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tready    = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = '0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [31:0] m_tdata;

    bit gaps_on = 1'b1;
    int req_count[4];
    int settings_used;
    int hash_errors;
    int hashes_compared;
    int hashes_pending;

    rolling_polynomial_hash_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    rolling_hash_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .hash_errors     (hash_errors),
        .hashes_compared (hashes_compared),
        .hashes_pending  (hashes_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= !(gaps_on && $urandom_range(99) < 15);
    end

    task automatic send_req(input rph_pkg::req_t req, input logic [7:0] nb,
                            input logic [7:0] ob);
        if (gaps_on && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {ob, nb};
        do @(posedge aclk); while (!s_tready);
        req_count[req]++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (hashes_pending != 0 || !s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(input rph_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [31:0] base, input logic [31:0] modulus,
                            input logic [15:0] window);
        wait_idle();
        write_reg(rph_pkg::CFG_BASE, base);
        write_reg(rph_pkg::CFG_MODULUS, modulus);
        write_reg(rph_pkg::CFG_WINDOW, {16'd0, window});
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [31:0] pick_base();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(2, 300);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(9))
            0:       return $urandom_range(0, 1);
            1:       return 32'd2;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(3, 255);
            default: return $urandom_range(256, 32'hFFFF_FFFF);
        endcase
    endfunction

    function automatic logic [15:0] pick_window();
        case ($urandom_range(9))
            0:       return 16'($urandom_range(0, 1));
            7, 8:    return 16'($urandom_range(9, 64));
            9:       return rph_pkg::WINDOW_RST;
            default: return 16'($urandom_range(2, 8));
        endcase
    endfunction

    // prepare first, fill the window, then mostly roll with the byte that leaves it
    task automatic run_phase(input int n_items, input logic [15:0] window);
        logic [7:0]    window_bytes[$];
        logic [7:0]    nb;
        logic [7:0]    ob;
        rph_pkg::req_t req;
        int            span;
        int            roll;
        bit            primed;
        span   = (window == 16'd0) ? 1 : int'(window);
        primed = 1'b0;
        repeat (n_items) begin
            nb   = 8'($urandom);
            roll = $urandom_range(99);
            if (roll < 8) begin
                req = rph_pkg::req_t'($urandom_range(3));
                ob  = 8'($urandom);
                if (req == rph_pkg::REQ_PREPARE || req == rph_pkg::REQ_CLEAR) begin
                    window_bytes.delete();
                end
                if (req == rph_pkg::REQ_PREPARE) primed = 1'b1;
                send_req(req, nb, ob);
            end else if (!primed || roll < 10) begin
                window_bytes.delete();
                primed = 1'b1;
                send_req(rph_pkg::REQ_PREPARE, nb, 8'($urandom));
            end else if (roll < 12) begin
                window_bytes.delete();
                send_req(rph_pkg::REQ_CLEAR, nb, 8'($urandom));
            end else if (window_bytes.size() < span) begin
                window_bytes.push_back(nb);
                send_req(rph_pkg::REQ_APPEND, nb, 8'($urandom));
            end else begin
                ob = window_bytes.pop_front();
                window_bytes.push_back(nb);
                send_req(rph_pkg::REQ_ROLL, nb, ob);
            end
            if ($urandom_range(199) == 0) wait_idle();
        end
    endtask

    initial begin : stimulus
        logic [15:0] window;
        settings_used = 1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // values after reset
        send_req(rph_pkg::REQ_APPEND, 8'h00, 8'h00);
        send_req(rph_pkg::REQ_APPEND, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_ROLL, 8'h00, 8'h00);
        send_req(rph_pkg::REQ_CLEAR, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_PREPARE, 8'h00, 8'h00);
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_APPEND, 8'h7F, 8'h80);

        // smallest legal modulus and window, largest base
        set_regs(32'hFFFF_FFFF, 32'd2, 16'd1);
        send_req(rph_pkg::REQ_PREPARE, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_APPEND, 8'hFF, 8'h00);
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);

        // modulus zero and window zero
        set_regs(32'd5, 32'd0, 16'd0);
        send_req(rph_pkg::REQ_PREPARE, 8'h01, 8'h01);
        send_req(rph_pkg::REQ_APPEND, 8'hFF, 8'h00);
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_CLEAR, 8'h00, 8'h00);

        // modulus one
        wait_idle();
        write_reg(rph_pkg::CFG_MODULUS, 32'd1);
        cfg_wr_en <= 1'b0;
        settings_used++;
        send_req(rph_pkg::REQ_APPEND, 8'h80, 8'h7F);

        // largest modulus, base one
        set_regs(32'd1, 32'hFFFF_FFFF, 16'd3);
        send_req(rph_pkg::REQ_PREPARE, 8'h00, 8'h00);
        send_req(rph_pkg::REQ_APPEND, 8'hFF, 8'h00);
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);

        // modulus changed after prepare, stale power and hash
        wait_idle();
        write_reg(rph_pkg::CFG_MODULUS, 32'd1000);
        cfg_wr_en <= 1'b0;
        settings_used++;
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_APPEND, 8'h55, 8'hAA);

        // longest window, one full prepare
        set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFB, 16'hFFFF);
        send_req(rph_pkg::REQ_PREPARE, 8'h00, 8'h00);
        send_req(rph_pkg::REQ_ROLL, 8'hFF, 8'hFF);
        send_req(rph_pkg::REQ_APPEND, 8'h01, 8'hFE);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            window = pick_window();
            set_regs(pick_base(), pick_modulus(), window);
            gaps_on <= (p != 3);
            run_phase(ITEMS_PER_PHASE, window);
        end

        wait_idle();
        repeat (50) @(posedge aclk);
        $display("%0d requests: %0d append, %0d roll, %0d clear, %0d prepare",
                 req_count[rph_pkg::REQ_APPEND] + req_count[rph_pkg::REQ_ROLL]
                 + req_count[rph_pkg::REQ_CLEAR] + req_count[rph_pkg::REQ_PREPARE],
                 req_count[rph_pkg::REQ_APPEND], req_count[rph_pkg::REQ_ROLL],
                 req_count[rph_pkg::REQ_CLEAR], req_count[rph_pkg::REQ_PREPARE]);
        $display("%0d hashes compared over %0d register settings, window up to 65535",
                 hashes_compared, settings_used);
        if (hash_errors == 0 && hashes_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #400_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
